FILE: hw/rtl/tdpt_pkg.sv
`timescale 1ns / 1ps

package tdpt_pkg;

	// default operand width
	localparam int WIDTH_DEFAULT = 32;

	// sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

endpackage

FILE: hw/rtl/trial_division_prime_test.sv
`timescale 1ns / 1ps

// Trial-division primality test. Pulse start with number while busy is low;
// exactly one result follows as a one-cycle pulse on done with is_prime, and
// it cannot be held off, so the receiver must take it in that cycle.
// Zero, one, two and even numbers are decided at once: done pulses on the
// cycle after the transaction. Odd numbers of three and up go through the
// bit-serial divider with odd divisors 3, 5, 7, ... until the quotient drops
// below the divisor (divisor squared exceeds number) or a remainder is zero.
// Each trial divisor takes a full pass through the divider, so a prime near
// 2^WIDTH needs about 2^(WIDTH/2) / 2 trial divisors. A new transaction is
// taken in the cycle that the previous result is shown.
module trial_division_prime_test #(
	parameter int WIDTH = tdpt_pkg::WIDTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [WIDTH-1:0] number,
	output logic             done,
	output logic             is_prime
);

	localparam logic [WIDTH-1:0] TWO   = WIDTH'(2);
	localparam logic [WIDTH-1:0] THREE = WIDTH'(3);

	tdpt_pkg::state_t state_q, state_d;

	logic [WIDTH-1:0] n_q, n_d;      // candidate under test
	logic [WIDTH-1:0] d_q, d_d;      // current trial divisor
	logic             done_q, done_d;
	logic             prime_q, prime_d;

	logic             div_go;
	logic             div_fin;
	logic [WIDTH-1:0] div_quo;
	logic [WIDTH-1:0] div_rem;

	// serial divider does one remainder per trial divisor
	tdpt_div #(
		.WIDTH(WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (n_d),
		.divisor  (d_q),
		.fin      (div_fin),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdpt_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		n_q     <= n_d;
		d_q     <= d_d;
		prime_q <= prime_d;
	end

	always_comb begin
		state_d = state_q;
		n_d     = n_q;
		d_d     = d_q;
		done_d  = 1'b0;
		prime_d = prime_q;
		div_go  = 1'b0;
		case (state_q)
			tdpt_pkg::ST_IDLE: begin
				if (start) begin
					n_d = number;
					if (number < TWO) begin
						// zero and one are not prime
						done_d  = 1'b1;
						prime_d = 1'b0;
					end else if (number == TWO) begin
						done_d  = 1'b1;
						prime_d = 1'b1;
					end else if (!number[0]) begin
						// even and above two
						done_d  = 1'b1;
						prime_d = 1'b0;
					end else begin
						d_d     = THREE;
						div_go  = 1'b1;
						state_d = tdpt_pkg::ST_DIV;
					end
				end
			end
			tdpt_pkg::ST_DIV: begin
				if (div_fin) begin
					if (div_quo < d_q) begin
						// divisor squared exceeds n: no factor left to find
						done_d  = 1'b1;
						prime_d = 1'b1;
						state_d = tdpt_pkg::ST_IDLE;
					end else if (div_rem == '0) begin
						done_d  = 1'b1;
						prime_d = 1'b0;
						state_d = tdpt_pkg::ST_IDLE;
					end else begin
						// next odd divisor
						d_d    = d_q + TWO;
						div_go = 1'b1;
					end
				end
			end
			default: begin
				state_d = tdpt_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy     = (state_q != tdpt_pkg::ST_IDLE);
	assign done     = done_q;
	assign is_prime = prime_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while search still running");

	a_small_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (number < TWO)) |=> (done && !is_prime))
		else $error("zero or one not rejected at once");

	a_odd_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (d_q[0] && n_q[0]))
		else $error("search running with even divisor or candidate");

	a_fin_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		div_fin |-> busy)
		else $error("divider finished outside a search");

endmodule

FILE: hw/rtl/tdpt_div.sv
`timescale 1ns / 1ps

// bit-serial restoring divider, one quotient bit per cycle
module tdpt_div #(
	parameter int WIDTH = tdpt_pkg::WIDTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             fin,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder
);

	localparam int CW = (WIDTH > 2) ? $clog2(WIDTH) : 1;

	logic [WIDTH-1:0] dvd_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             fin_q;

	logic [WIDTH:0] trial;
	logic [WIDTH:0] diff;
	logic           ge;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, dvd_q[WIDTH-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(WIDTH - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
			rem_q <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], ge};
		end
	end

	assign fin       = fin_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> !run_q)
		else $error("divider restarted while running");

endmodule
